// ----- sv/wmie_pkg.sv -----
// wmie_pkg: shared codes for the word machine instruction executor
// request kinds, status codes, opcodes and fixed field widths
// no dependencies
package wmie_pkg;

    localparam int REG_COUNT = 32;
    localparam int RIDX_W    = 5;
    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 14;

    // request kinds
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STEP    = 2'd1;
    localparam logic [1:0] REQ_RD_REG  = 2'd2;
    localparam logic [1:0] REQ_RD_MEM  = 2'd3;

    // status codes, sticky once not ok
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_ADDR  = 2'd3;

    localparam logic [7:0] HALT_BYTE = 8'hFF;

    // opcodes
    localparam logic [7:0] OP_NOP = 8'd0;
    localparam logic [7:0] OP_ADD = 8'd1;
    localparam logic [7:0] OP_SUB = 8'd2;
    localparam logic [7:0] OP_AND = 8'd3;
    localparam logic [7:0] OP_ORR = 8'd4;
    localparam logic [7:0] OP_XOR = 8'd5;
    localparam logic [7:0] OP_NOT = 8'd6;
    localparam logic [7:0] OP_LSH = 8'd7;
    localparam logic [7:0] OP_ASH = 8'd8;
    localparam logic [7:0] OP_TCU = 8'd9;
    localparam logic [7:0] OP_TCS = 8'd10;
    localparam logic [7:0] OP_SET = 8'd11;
    localparam logic [7:0] OP_MOV = 8'd12;
    localparam logic [7:0] OP_LDW = 8'd13;
    localparam logic [7:0] OP_STW = 8'd14;
    localparam logic [7:0] OP_LDB = 8'd15;
    localparam logic [7:0] OP_STB = 8'd16;

endpackage

// ----- sv/wmie_ram.sv -----
// wmie_ram: generic single write port, single read port ram
// read data is registered; no dependencies
module wmie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/word_machine_instruction_executor.sv -----
// word_machine_instruction_executor: top level of the word machine
// depends on wmie_pkg and wmie_ram (word memory and register file)
//
// After reset the block sweeps the word memory to zero, one word a cycle; no request is taken
// during the sweep, configuration writes are. Requests are then taken one at a time. A load
// goes from acceptance to the result register, a register or memory read passes through its
// read state, and a step runs the instruction fetch from the word memory, the reads of rB, rC
// and rA through the single read port of the register file ram, execution, a data load for
// LDW and LDB, and the posting of the result. The next request is taken the cycle after the
// result is posted, even while that result still waits on m_axis_tready. The program counter
// (register 0) is held in flip-flops.
module word_machine_instruction_executor #(
    parameter int MEM_WORDS   = 16384,
    parameter int STACK_START = 1000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: program_base
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [wmie_pkg::ADDR_W-1:0] i_cfg_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // mem_address[13:0], load_data[45:14], reg_select[50:46]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // pc_after[31:0], written_index[36:32], read_value[68:37]
    output logic [2:0]  m_axis_tuser   // status[1:0], reg_written[2]
);

    import wmie_pkg::*;

    localparam int MAW = $clog2(MEM_WORDS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RREG, S_RMEM, S_FETCH,
        S_RDB, S_RDC, S_RDA, S_EXEC, S_LOAD, S_DONE
    } t_state;

    t_state r_state;

    logic [MAW-1:0]        r_clr;
    logic [ADDR_W-1:0]     r_base;
    logic [WORD_W-1:0]     r_pc;
    logic [1:0]            r_stopped;
    logic [REG_COUNT-1:0]  r_rvalid;
    logic [RIDX_W-1:0]     r_sel;
    logic [WORD_W-1:0]     r_word;
    logic [WORD_W-1:0]     r_a;
    logic [WORD_W-1:0]     r_b;
    logic [WORD_W-1:0]     r_c;
    logic [WORD_W-1:0]     r_rv;
    logic                  r_wflag;
    logic [RIDX_W-1:0]     r_widx;

    logic                  r_out_valid;
    logic [1:0]            r_o_status;
    logic [WORD_W-1:0]     r_o_pc;
    logic                  r_o_wflag;
    logic [RIDX_W-1:0]     r_o_widx;
    logic [WORD_W-1:0]     r_o_rv;
    logic                  w_post;

    // request fields
    logic [1:0]            w_req;
    logic [ADDR_W-1:0]     w_addr;
    logic [WORD_W-1:0]     w_addr32;
    logic [WORD_W-1:0]     w_ldata;
    logic [RIDX_W-1:0]     w_rsel;
    logic                  w_accept;
    logic                  w_addr_ok;
    logic [WORD_W:0]       w_fa;
    logic                  w_fa_ok;

    // memories
    logic                  w_mem_we;
    logic [MAW-1:0]        w_mem_waddr;
    logic [WORD_W-1:0]     w_mem_wdata;
    logic [MAW-1:0]        w_mem_raddr;
    logic [WORD_W-1:0]     w_mem_rdata;
    logic                  w_reg_we;
    logic [RIDX_W-1:0]     w_reg_waddr;
    logic [WORD_W-1:0]     w_reg_wdata;
    logic [RIDX_W-1:0]     w_reg_raddr;
    logic [WORD_W-1:0]     w_reg_rdata;

    // instruction decode and execute
    logic [7:0]            w_op;
    logic [RIDX_W-1:0]     w_ra;
    logic [RIDX_W-1:0]     w_rb;
    logic [RIDX_W-1:0]     w_rc;
    logic [15:0]           w_imm;
    logic                  w_neg;
    logic [WORD_W-1:0]     w_mag;
    logic [4:0]            w_amt;
    logic                  w_sh_bad;
    logic [WORD_W-1:0]     n_val;
    logic                  n_wr;
    logic [1:0]            n_err;
    logic                  n_mem_rd;
    logic                  n_mem_wr;
    logic [WORD_W-1:0]     w_ld_val;

    assign w_req    = s_axis_tuser;
    assign w_addr   = s_axis_tdata[13:0];
    assign w_ldata  = s_axis_tdata[45:14];
    assign w_rsel   = s_axis_tdata[50:46];
    assign w_addr32 = WORD_W'(w_addr);
    assign w_addr_ok = w_addr32 < WORD_W'(MEM_WORDS);
    assign w_fa     = {1'b0, r_pc} + (WORD_W + 1)'(r_base);
    assign w_fa_ok  = w_fa < (WORD_W + 1)'(MEM_WORDS);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // result register loads when the slot is empty or being drained
    assign w_post = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // register value with pc for index 0 and reset values for unwritten entries
    function automatic logic [WORD_W-1:0] reg_value(
        input logic [RIDX_W-1:0]    idx,
        input logic [WORD_W-1:0]    rdata,
        input logic [REG_COUNT-1:0] valid,
        input logic [WORD_W-1:0]    pc
    );
        logic [WORD_W-1:0] v;
        if (idx == '0) begin
            v = pc;
        end else if (!valid[idx]) begin
            v = (idx == RIDX_W'(REG_COUNT - 1)) ? WORD_W'(STACK_START) : '0;
        end else begin
            v = rdata;
        end
        return v;
    endfunction

    assign w_op  = r_word[7:0];
    assign w_ra  = r_word[12:8];
    assign w_rb  = r_word[20:16];
    assign w_rc  = r_word[28:24];
    assign w_imm = r_word[31:16];

    assign w_neg    = r_c[WORD_W-1];
    assign w_mag    = w_neg ? (~r_c + WORD_W'(1)) : r_c;
    assign w_sh_bad = |w_mag[WORD_W-1:5];
    assign w_amt    = w_mag[4:0];

    always_comb begin
        n_val    = '0;
        n_wr     = 1'b0;
        n_err    = ST_OK;
        n_mem_rd = 1'b0;
        n_mem_wr = 1'b0;
        case (w_op)
            OP_ADD: begin n_val = r_b + r_c; n_wr = 1'b1; end
            OP_SUB: begin n_val = r_b - r_c; n_wr = 1'b1; end
            OP_AND: begin n_val = r_b & r_c; n_wr = 1'b1; end
            OP_ORR: begin n_val = r_b | r_c; n_wr = 1'b1; end
            OP_XOR: begin n_val = r_b ^ r_c; n_wr = 1'b1; end
            OP_NOT: begin n_val = ~r_b; n_wr = 1'b1; end
            OP_LSH, OP_ASH: begin
                if (w_sh_bad) begin
                    n_err = ST_SHIFT;
                end else begin
                    n_wr = 1'b1;
                    if (!w_neg) begin
                        n_val = r_b << w_amt;
                    end else if (w_op == OP_LSH) begin
                        n_val = r_b >> w_amt;
                    end else begin
                        n_val = WORD_W'($signed(r_b) >>> w_amt);
                    end
                end
            end
            OP_TCU: begin
                n_wr  = 1'b1;
                n_val = (r_b == r_c) ? '0 : ((r_b > r_c) ? WORD_W'(1) : '1);
            end
            OP_TCS: begin
                n_wr  = 1'b1;
                n_val = (r_b == r_c) ? '0
                      : (($signed(r_b) > $signed(r_c)) ? WORD_W'(1) : '1);
            end
            OP_SET: begin
                n_wr  = 1'b1;
                n_val = {{(WORD_W - 16){w_imm[15]}}, w_imm};
            end
            OP_MOV: begin n_val = r_b; n_wr = 1'b1; end
            OP_LDW, OP_LDB: begin
                if (r_b >= WORD_W'(MEM_WORDS)) begin
                    n_err = ST_ADDR;
                end else begin
                    n_mem_rd = 1'b1;
                end
            end
            OP_STW, OP_STB: begin
                if (r_a >= WORD_W'(MEM_WORDS)) begin
                    n_err = ST_ADDR;
                end else begin
                    n_mem_wr = 1'b1;
                end
            end
            default: begin
                n_wr = 1'b0;
            end
        endcase
    end

    assign w_ld_val = (w_op == OP_LDB) ? {{(WORD_W - 8){1'b0}}, w_mem_rdata[7:0]} : w_mem_rdata;

    // word memory port control
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = '0;
        w_mem_wdata = '0;
        w_mem_raddr = '0;
        case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr;
            end
            S_IDLE: begin
                if (w_accept && w_req == REQ_LOAD && w_addr_ok) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = w_addr32[MAW-1:0];
                    w_mem_wdata = w_ldata;
                end
                w_mem_raddr = (w_req == REQ_STEP) ? w_fa[MAW-1:0] : w_addr32[MAW-1:0];
            end
            S_EXEC: begin
                w_mem_raddr = r_b[MAW-1:0];
                if (n_mem_wr) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = r_a[MAW-1:0];
                    w_mem_wdata = (w_op == OP_STW) ? r_b : {{(WORD_W - 8){1'b0}}, r_b[7:0]};
                end
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // register file port control; register 0 lives in r_pc
    always_comb begin
        w_reg_we    = 1'b0;
        w_reg_waddr = w_ra;
        w_reg_wdata = n_val;
        w_reg_raddr = '0;
        case (r_state)
            S_IDLE:  w_reg_raddr = w_rsel;
            S_FETCH: w_reg_raddr = w_mem_rdata[20:16];
            S_RDB:   w_reg_raddr = w_rc;
            S_RDC:   w_reg_raddr = w_ra;
            S_EXEC: begin
                w_reg_we = (n_err == ST_OK) && n_wr && (w_ra != '0);
            end
            S_LOAD: begin
                w_reg_we    = (w_ra != '0);
                w_reg_wdata = w_ld_val;
            end
            default: begin
                w_reg_raddr = '0;
            end
        endcase
    end

    wmie_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    wmie_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_regs (
        .i_clk   (i_clk),
        .i_we    (w_reg_we),
        .i_waddr (w_reg_waddr),
        .i_wdata (w_reg_wdata),
        .i_raddr (w_reg_raddr),
        .o_rdata (w_reg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_base      <= '0;
            r_pc        <= '0;
            r_stopped   <= ST_OK;
            r_rvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + MAW'(1);
                    if (r_clr == MAW'(MEM_WORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_sel   <= w_rsel;
                        r_rv    <= '0;
                        r_wflag <= 1'b0;
                        r_widx  <= '0;
                        case (w_req)
                            REQ_LOAD:   r_state <= S_DONE;
                            REQ_RD_REG: r_state <= S_RREG;
                            REQ_RD_MEM: r_state <= w_addr_ok ? S_RMEM : S_DONE;
                            REQ_STEP: begin
                                if (r_stopped != ST_OK) begin
                                    r_state <= S_DONE;
                                end else if (!w_fa_ok) begin
                                    r_stopped <= ST_ADDR;
                                    r_state   <= S_DONE;
                                end else begin
                                    r_state <= S_FETCH;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RREG: begin
                    r_rv    <= reg_value(r_sel, w_reg_rdata, r_rvalid, r_pc);
                    r_state <= S_DONE;
                end
                S_RMEM: begin
                    r_rv    <= w_mem_rdata;
                    r_state <= S_DONE;
                end
                S_FETCH: begin
                    r_word <= w_mem_rdata;
                    if (w_mem_rdata[7:0] == HALT_BYTE) begin
                        r_stopped <= ST_HALT;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_RDB;
                    end
                end
                S_RDB: begin
                    r_b     <= reg_value(w_rb, w_reg_rdata, r_rvalid, r_pc);
                    r_state <= S_RDC;
                end
                S_RDC: begin
                    r_c     <= reg_value(w_rc, w_reg_rdata, r_rvalid, r_pc);
                    r_state <= S_RDA;
                end
                S_RDA: begin
                    r_a     <= reg_value(w_ra, w_reg_rdata, r_rvalid, r_pc);
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (n_err != ST_OK) begin
                        r_stopped <= n_err;
                        r_state   <= S_DONE;
                    end else if (n_mem_rd) begin
                        r_state <= S_LOAD;
                    end else begin
                        if (n_wr) begin
                            r_rv    <= n_val;
                            r_wflag <= 1'b1;
                            r_widx  <= w_ra;
                            r_rvalid[w_ra] <= 1'b1;
                        end
                        // pc increments after the write, so a write to pc lands plus one
                        r_pc    <= ((n_wr && w_ra == '0) ? n_val : r_pc) + WORD_W'(1);
                        r_state <= S_DONE;
                    end
                end
                S_LOAD: begin
                    r_rv    <= w_ld_val;
                    r_wflag <= 1'b1;
                    r_widx  <= w_ra;
                    r_rvalid[w_ra] <= 1'b1;
                    r_pc    <= ((w_ra == '0) ? w_ld_val : r_pc) + WORD_W'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_post) begin
                        r_o_status  <= r_stopped;
                        r_o_pc      <= r_pc;
                        r_o_wflag   <= r_wflag;
                        r_o_widx    <= r_widx;
                        r_o_rv      <= r_rv;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_o_rv, r_o_widx, r_o_pc};
    assign m_axis_tuser  = {r_o_wflag, r_o_status};

endmodule

// ----- sv/wmie_checker.sv -----
// wmie_checker: port level checks for the word machine executor
// depends on wmie_pkg; bound to word_machine_instruction_executor below
module wmie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    import wmie_pkg::*;

    logic [1:0] r_last_status;
    logic       w_out_take;

    assign w_out_take = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_status <= ST_OK;
        end else if (w_out_take) begin
            r_last_status <= m_axis_tuser[1:0];
        end
    end

    // no result shows up right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // halt and errors are sticky until reset
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take && r_last_status != ST_OK |-> m_axis_tuser[1:0] == r_last_status)
        else $error("stopped status was lost");

    // a register write only comes from a step that succeeded
    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
        else $error("register write reported with a stopped status");

    // no written index without a write
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata[36:32] == '0)
        else $error("written index set without a write");

endmodule

bind word_machine_instruction_executor wmie_checker u_wmie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
